### src/grce_pkg.sv
package grce_pkg;

  localparam int NSTEP  = 20;
  localparam int STEP_W = $clog2(NSTEP);

  localparam logic [15:0] Q_ONE = 16'h8000;

  // configuration register indexes
  localparam logic CFG_TRIGGER_THRESHOLD = 1'b0;
  localparam logic CFG_STICK_DEADZONE    = 1'b1;

  typedef enum logic [1:0] {
    K_BTN,
    K_TRG,
    K_AXS
  } kind_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  // one control word of the scan program
  typedef struct packed {
    kind_t      kind;
    logic [3:0] sel;   // button bit, trigger index or axis index
    logic [4:0] id;    // event id (negative half for axes)
    logic       fin;   // final step of the program
  } ctl_t;

  typedef struct packed {
    logic [15:0]      buttons;
    logic [1:0][7:0]  trig;
    logic [3:0][15:0] axes;
  } report_t;

  typedef struct packed {
    logic [4:0]  id;
    logic        pressed;
    logic [15:0] mag;
  } event_t;

  // program ROM: buttons, triggers, then stick axes
  function automatic ctl_t grce_rom(input logic [STEP_W-1:0] s);
    ctl_t c;
    c.kind = K_BTN;
    c.sel  = 4'd0;
    c.id   = 5'd0;
    c.fin  = 1'b0;
    if (s inside {[0:9]}) begin
      c.kind = K_BTN;
      c.sel  = 4'(s);
      c.id   = 5'(s);
    end else if (s inside {[10:13]}) begin
      // skip the two unused button bits
      c.kind = K_BTN;
      c.sel  = 4'(s + 5'd2);
      c.id   = 5'(s);
    end else if (s inside {[14:15]}) begin
      c.kind = K_TRG;
      c.sel  = 4'(s - 5'd14);
      c.id   = 5'(s);
    end else if (s inside {[16:19]}) begin
      c.kind = K_AXS;
      c.sel  = 4'(s - 5'd16);
      c.id   = 5'(5'd16 + ((s - 5'd16) << 1));
      c.fin  = (s == 5'(NSTEP - 1));
    end
    return c;
  endfunction

  // floor(t * 32768 / 255) = 128t + floor(128t / 255)
  function automatic logic [15:0] trig_mag(input logic [7:0] t);
    logic [14:0] x;
    logic [23:0] p;
    logic [7:0]  q;
    logic [14:0] r;
    x = {t, 7'd0};
    p = {x, 8'd0} + 24'(x);
    q = p[23:16];
    r = x - (15'(q) * 15'd255);
    if (r >= 15'd255) q = q + 8'd1;
    return 16'(x) + 16'(q);
  endfunction

endpackage

### src/gamepad_report_change_events.sv
// Gamepad report change detector. Each accepted report whose packet number
// is greater than the stored one is scanned by a 20-step program (14
// buttons, 2 triggers, 4 stick axes), one control per cycle while the
// output is not stalled; each changed control puts one item on the output,
// the final one flagged by last_event. The scan ends on the step after which
// no changed control remains, and a fresh report holds the input until then;
// a stale report is dropped in its accept cycle. The next report is taken
// once the scan has finished, while the final item may still wait.
module gamepad_report_change_events (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        packet_number,
  input  logic [15:0]        button_bits,
  input  logic [7:0]         left_trigger,
  input  logic [7:0]         right_trigger,
  input  logic signed [15:0] left_x,
  input  logic signed [15:0] left_y,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         control_id,
  output logic               is_pressed,
  output logic [15:0]        magnitude,
  output logic               last_event
);
  import grce_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [7:0]        trigger_threshold;
  logic [14:0]       stick_deadzone;
  logic [31:0]       prev_packet;
  logic [31:0]       cur_packet;
  report_t           prev;
  report_t           cur;
  ctl_t              ctl;
  event_t            ev;
  logic [NSTEP-1:0]  chg;
  logic [NSTEP-1:0]  later;
  logic              accept;
  logic              fresh;
  logic              adv;
  logic              tail_empty;
  logic              done;
  logic              commit;

  grce_eval u_eval (
    .ctl               (ctl),
    .cur               (cur),
    .prev              (prev),
    .trigger_threshold (trigger_threshold),
    .stick_deadzone    (stick_deadzone),
    .ev                (ev),
    .chg               (chg)
  );

  assign ctl        = grce_rom(step);
  assign accept     = in_valid && in_ready;
  assign fresh      = packet_number > prev_packet;
  assign adv        = (state == S_RUN) && (!out_valid || out_ready);
  assign later      = ~((NSTEP'(2) << step) - NSTEP'(1));
  assign tail_empty = ~|(chg & later);
  assign done       = ctl.fin || tail_empty;

  always_comb begin
    state_next = state;
    step_next  = step;
    commit     = 1'b0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (accept && fresh) begin
          state_next = S_RUN;
          step_next  = '0;
        end
      end
      S_RUN: begin
        if (adv) begin
          if (done) begin
            state_next = S_IDLE;
            commit     = 1'b1;
          end else begin
            step_next = step + STEP_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_threshold <= 8'd30;
      stick_deadzone    <= 15'd8689;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_THRESHOLD: trigger_threshold <= cfg_data[7:0];
        CFG_STICK_DEADZONE:    stick_deadzone    <= cfg_data;
        default:               trigger_threshold <= trigger_threshold;
      endcase
    end
  end

  // hold the report under scan
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_packet  <= packet_number;
      cur.buttons <= button_bits;
      cur.trig    <= {right_trigger, left_trigger};
      cur.axes    <= {right_y, right_x, left_y, left_x};
    end
  end

  // stored report advances once the scan is over
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_packet <= '0;
      prev        <= '0;
    end else if (commit) begin
      prev_packet <= cur_packet;
      prev        <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && chg[step]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && chg[step]) begin
      control_id <= ev.id;
      is_pressed <= ev.pressed;
      magnitude  <= ev.mag;
      last_event <= tail_empty;
    end
  end

`ifndef SYNTH
  // a new scan waits at its first step behind the previous report's final item
  a_wait_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && out_valid && last_event) |-> step == '0)
    else $error("scan advanced past final item still pending");

  a_packet_grows: assert property (@(posedge clk) disable iff (rst)
    !rst |=> prev_packet >= $past(prev_packet))
    else $error("stored packet number went backwards");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step < STEP_W'(NSTEP))
    else $error("step counter beyond program");
`endif

endmodule

### src/grce_eval.sv
module grce_eval (
  input  grce_pkg::ctl_t              ctl,
  input  grce_pkg::report_t           cur,
  input  grce_pkg::report_t           prev,
  input  logic [7:0]                  trigger_threshold,
  input  logic [14:0]                 stick_deadzone,
  output grce_pkg::event_t            ev,
  output logic [grce_pkg::NSTEP-1:0]  chg
);
  import grce_pkg::*;

  ctl_t               c;
  logic [7:0]         t;
  logic signed [15:0] v;
  logic signed [15:0] o;
  logic signed [16:0] vx;
  logic [16:0]        nv;

  // change flag for every step of the program
  always_comb begin
    c = '0;
    for (int s = 0; s < NSTEP; s++) begin
      c = grce_rom(STEP_W'(s));
      case (c.kind)
        K_BTN:   chg[s] = cur.buttons[c.sel] != prev.buttons[c.sel];
        K_TRG:   chg[s] = cur.trig[c.sel[0]] != prev.trig[c.sel[0]];
        K_AXS:   chg[s] = cur.axes[c.sel[1:0]] != prev.axes[c.sel[1:0]];
        default: chg[s] = 1'b0;
      endcase
    end
  end

  always_comb begin
    t  = cur.trig[ctl.sel[0]];
    v  = cur.axes[ctl.sel[1:0]];
    o  = prev.axes[ctl.sel[1:0]];
    vx = 17'(v);
    nv = 17'(-vx);
    ev.id      = ctl.id;
    ev.pressed = 1'b0;
    ev.mag     = 16'd0;
    case (ctl.kind)
      K_BTN: begin
        ev.pressed = cur.buttons[ctl.sel];
        ev.mag     = cur.buttons[ctl.sel] ? Q_ONE : 16'd0;
      end
      K_TRG: begin
        ev.pressed = t > trigger_threshold;
        ev.mag     = trig_mag(t);
      end
      K_AXS: begin
        if (v > 16'sd0) begin
          ev.id      = ctl.id + 5'd1;
          ev.pressed = v[14:0] > stick_deadzone;
          // v * 32768 / 32767 floors to v, except at full scale
          ev.mag     = (v == 16'sd32767) ? Q_ONE : 16'(v);
        end else if (v < 16'sd0) begin
          ev.pressed = nv[15:0] > {1'b0, stick_deadzone};
          ev.mag     = nv[15:0];
        end else begin
          // back to zero: release the half that was left
          ev.id = (o > 16'sd0) ? ctl.id + 5'd1 : ctl.id;
        end
      end
      default: begin
        ev.pressed = 1'b0;
      end
    endcase
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import grce_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES   = 40;

  typedef enum logic [1:0] {
    OP_REPORT,
    OP_CONFIG,
    OP_DRAIN
  } op_kind_t;

  // one pending driver action: a report, a register write or a drain pause
  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       gap;
    logic [31:0]      packet;
    logic [15:0]      buttons;
    logic [1:0][7:0]  trig;   // 0 left, 1 right
    logic [3:0][15:0] axes;   // left x, left y, right x, right y
    logic             cfg_sel;
    logic [14:0]      cfg_value;
  } pad_op_t;

  typedef struct packed {
    logic [4:0]  id;
    logic        pressed;
    logic [15:0] mag;
    logic        last;
  } ctrl_event_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_we        = 1'b0;
  logic               cfg_index     = 1'b0;
  logic [14:0]        cfg_data      = '0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [31:0]        packet_number = '0;
  logic [15:0]        button_bits   = '0;
  logic [7:0]         left_trigger  = '0;
  logic [7:0]         right_trigger = '0;
  logic signed [15:0] left_x        = '0;
  logic signed [15:0] left_y        = '0;
  logic signed [15:0] right_x       = '0;
  logic signed [15:0] right_y       = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [4:0]         control_id;
  logic               is_pressed;
  logic [15:0]        magnitude;
  logic               last_event;

  pad_op_t     pending_ops[$];
  ctrl_event_t expected_events[$];
  pad_op_t     held_op;
  bit          tx_holding = 1'b0;
  int          tx_gap     = 0;
  int          tx_settle  = 0;
  int          rx_stall   = 0;
  int          rx_calm    = 0;
  int          fault_count = 0;

  // stored report and register copies for prediction
  logic [31:0]      held_packet   = '0;
  logic [15:0]      held_buttons  = '0;
  logic [1:0][7:0]  held_trig     = '0;
  logic [3:0][15:0] held_axes     = '0;
  logic [7:0]       cur_threshold = 8'd30;
  logic [14:0]      cur_deadzone  = 15'd8689;

  gamepad_report_change_events u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .packet_number (packet_number),
    .button_bits   (button_bits),
    .left_trigger  (left_trigger),
    .right_trigger (right_trigger),
    .left_x        (left_x),
    .left_y        (left_y),
    .right_x       (right_x),
    .right_y       (right_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .control_id    (control_id),
    .is_pressed    (is_pressed),
    .magnitude     (magnitude),
    .last_event    (last_event)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_event(input logic [4:0] id, input logic pressed,
                                     input logic [15:0] mag);
    expected_events.push_back({id, pressed, mag, 1'b0});
  endfunction

  function automatic void predict_report_events(input pad_op_t r);
    ctrl_event_t tail;
    int n;
    int bit_pos;
    int nv;
    int ov;
    int dz;
    n = 0;
    // drop stale and repeated packets
    if (r.packet <= held_packet) return;
    dz = int'(cur_deadzone);
    for (int id = 0; id < 14; id++) begin
      bit_pos = (id < 10) ? id : id + 2;
      if (r.buttons[bit_pos] != held_buttons[bit_pos]) begin
        push_event(5'(id), r.buttons[bit_pos], r.buttons[bit_pos] ? Q_ONE : 16'd0);
        n++;
      end
    end
    for (int t = 0; t < 2; t++) begin
      if (r.trig[t] != held_trig[t]) begin
        push_event(5'(14 + t), r.trig[t] > cur_threshold,
                   16'((32'(r.trig[t]) * 32'd32768) / 32'd255));
        n++;
      end
    end
    for (int a = 0; a < 4; a++) begin
      nv = int'($signed(r.axes[a]));
      ov = int'($signed(held_axes[a]));
      if (nv != ov) begin
        n++;
        if (nv > 0) push_event(5'(17 + 2 * a), nv > dz, 16'((nv * 32768) / 32767));
        else if (nv < 0) push_event(5'(16 + 2 * a), nv < -dz, 16'(-nv));
        // back at zero: release the half the axis came from
        else if (ov > 0) push_event(5'(17 + 2 * a), 1'b0, 16'd0);
        else push_event(5'(16 + 2 * a), 1'b0, 16'd0);
      end
    end
    if (n > 0) begin
      tail = expected_events[expected_events.size() - 1];
      tail.last = 1'b1;
      expected_events[expected_events.size() - 1] = tail;
    end
    held_packet  = r.packet;
    held_buttons = r.buttons;
    held_trig    = r.trig;
    held_axes    = r.axes;
  endfunction

  function automatic void note_fault(input string what, input ctrl_event_t want,
                                     input ctrl_event_t got);
    if (fault_count < 10)
      $display({"%0t %s: expected id %0d pressed %0d mag %0d last %0d",
                "; got id %0d pressed %0d mag %0d last %0d"},
               $realtime, what, want.id, want.pressed, want.mag, want.last,
               got.id, got.pressed, got.mag, got.last);
    fault_count++;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_axis(input logic [15:0] old, input int dzv);
    case ($urandom_range(0, 9))
      0: return old;
      1: return 16'd0;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: begin
        if ($urandom_range(0, 1) == 1) return 16'(dzv + int'($urandom_range(0, 1)));
        return 16'(-dzv - int'($urandom_range(0, 1)));
      end
      5: return 16'(int'($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_trigger(input logic [7:0] old, input logic [7:0] thr);
    case ($urandom_range(0, 7))
      0: return old;
      1: return 8'd0;
      2: return 8'hFF;
      3: return thr;
      4: return 8'(thr + 8'd1);
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly small moves from the previous report, now and then a fresh one
  function automatic pad_op_t evolve_report(input pad_op_t prev, input logic [7:0] thr,
                                            input int dzv);
    pad_op_t r;
    int idx;
    r = prev;
    r.kind = OP_REPORT;
    if ($urandom_range(0, 6) == 0) begin
      r.buttons = 16'($urandom);
      for (int t = 0; t < 2; t++) r.trig[t] = 8'($urandom);
      for (int a = 0; a < 4; a++) r.axes[a] = 16'($urandom);
    end else begin
      repeat ($urandom_range(0, 3)) begin
        idx = $urandom_range(0, 15);
        r.buttons[idx] = ~r.buttons[idx];
      end
      for (int t = 0; t < 2; t++)
        if ($urandom_range(0, 2) == 0) r.trig[t] = pick_trigger(r.trig[t], thr);
      for (int a = 0; a < 4; a++)
        if ($urandom_range(0, 2) == 0) r.axes[a] = pick_axis(r.axes[a], dzv);
    end
    return r;
  endfunction

  function automatic pad_op_t make_report(input logic [31:0] pkt, input logic [15:0] btn,
                                          input int lt, input int rt, input int lx,
                                          input int ly, input int rx, input int ry);
    pad_op_t r;
    r = '0;
    r.kind    = OP_REPORT;
    r.gap     = 8'(pick_gap());
    r.packet  = pkt;
    r.buttons = btn;
    r.trig[0] = 8'(lt);
    r.trig[1] = 8'(rt);
    r.axes[0] = 16'(lx);
    r.axes[1] = 16'(ly);
    r.axes[2] = 16'(rx);
    r.axes[3] = 16'(ry);
    return r;
  endfunction

  function automatic void queue_control(input op_kind_t kind, input logic sel,
                                        input logic [14:0] value);
    pad_op_t r;
    r = '0;
    r.kind      = kind;
    r.cfg_sel   = sel;
    r.cfg_value = value;
    pending_ops.push_back(r);
  endfunction

  // driver: one item at a time from pending_ops
  always @(posedge clk) begin
    pad_op_t op;
    logic vld_n;
    logic we_n;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
      tx_gap = 0;
      tx_settle = 0;
    end else begin
      vld_n = in_valid;
      we_n = 1'b0;
      if (in_valid && in_ready) begin
        predict_report_events(held_op);
        vld_n = 1'b0;
        tx_holding = 1'b0;
      end
      if (!vld_n && pending_ops.size() != 0) begin
        op = pending_ops[0];
        if (op.kind == OP_REPORT) begin
          if (tx_gap < int'(op.gap)) begin
            tx_gap++;
          end else begin
            op = pending_ops.pop_front();
            held_op = op;
            tx_gap = 0;
            tx_holding = 1'b1;
            vld_n = 1'b1;
            packet_number <= op.packet;
            button_bits <= op.buttons;
            left_trigger <= op.trig[0];
            right_trigger <= op.trig[1];
            left_x <= op.axes[0];
            left_y <= op.axes[1];
            right_x <= op.axes[2];
            right_y <= op.axes[3];
          end
        end else begin
          // hold off until every item is out and the scan has had time to finish
          if (expected_events.size() == 0 && !out_valid) tx_settle++;
          else tx_settle = 0;
          if (tx_settle >= SETTLE_CYCLES) begin
            op = pending_ops.pop_front();
            tx_settle = 0;
            if (op.kind == OP_CONFIG) begin
              we_n = 1'b1;
              cfg_index <= op.cfg_sel;
              cfg_data <= op.cfg_value;
              if (op.cfg_sel == CFG_TRIGGER_THRESHOLD) cur_threshold = op.cfg_value[7:0];
              else cur_deadzone = op.cfg_value;
            end
          end
        end
      end
      in_valid <= vld_n;
      cfg_we <= we_n;
    end
  end

  // monitor: check each item against the oldest expectation, stall at random
  always @(posedge clk) begin
    ctrl_event_t got;
    ctrl_event_t want;
    logic rdy_n;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {control_id, is_pressed, magnitude, last_event};
        if (expected_events.size() == 0) begin
          note_fault("unexpected item", '0, got);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) note_fault("mismatch", want, got);
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        rdy_n = 1'b0;
      end else begin
        rdy_n = 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else if ($urandom_range(0, 63) == 0) begin
          rx_calm = $urandom_range(40, 200);
        end else if ($urandom_range(0, 3) == 0) begin
          rx_stall = pick_gap();
          rdy_n = (rx_stall == 0);
        end
      end
      out_ready <= rdy_n;
    end
  end

  initial begin
    pad_op_t r;
    pad_op_t last_good;
    logic [31:0] pkt;
    logic [7:0] thr;
    int dzv;
    bit calm;

    // packet zero straight after reset is not newer than the stored one
    pending_ops.push_back(make_report(0, 16'hFFFF, 255, 255, 32767, 32767, 32767, 32767));
    // every control pressed at full scale
    pending_ops.push_back(make_report(1, 16'hFFFF, 255, 255, 32767, -32768, 32767, -32768));
    pending_ops.push_back(make_report(1, 16'h0000, 7, 9, 100, 100, 100, 100));
    // everything back to rest, both halves released
    pending_ops.push_back(make_report(2, 16'h0000, 0, 0, 0, 0, 0, 0));
    // unused bits only, triggers and axes on the threshold edges
    pending_ops.push_back(make_report(3, 16'h0C00, 30, 31, 8689, -8689, 8690, -8690));
    pending_ops.push_back(make_report(4, 16'h0C00, 30, 31, 8689, -8689, 8690, -8690));
    // sign change without passing zero
    pending_ops.push_back(make_report(5, 16'h0C00, 31, 30, -1, 1, -8690, 8690));
    queue_control(OP_DRAIN, 1'b0, '0);
    pending_ops.push_back(make_report(3, 16'hFFFF, 200, 200, 5, 5, 5, 5));
    pending_ops.push_back(make_report(7, 16'h5555, 128, 1, 0, 0, 0, 0));
    pending_ops.push_back(make_report(8, 16'hAAAA, 254, 0, -32767, 32766, 1, -1));
    last_good = make_report(32'h0001_0000, 16'h8001, 255, 255, 32767, -32768, -32768, 32767);
    pending_ops.push_back(last_good);

    pkt = 32'h0001_0000;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin thr = 8'd0;   dzv = 0;     end
        1: begin thr = 8'hFF;  dzv = 32767; end
        2: begin thr = 8'd0;   dzv = 32767; end
        3: begin thr = 8'hFF;  dzv = 0;     end
        default: begin
          thr = 8'($urandom);
          dzv = $urandom_range(0, 32767);
        end
      endcase
      queue_control(OP_CONFIG, CFG_TRIGGER_THRESHOLD, {7'($urandom), thr});
      queue_control(OP_CONFIG, CFG_STICK_DEADZONE, 15'(dzv));
      calm = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < 50; k++) begin
        if (k == 25 && ph % 2 == 1) queue_control(OP_DRAIN, 1'b0, '0);
        if ($urandom_range(0, 9) == 0) begin
          // out-of-order packet with random content: must be dropped
          r = evolve_report(last_good, thr, dzv);
          r.packet = pkt - $urandom_range(0, 3);
          r.gap = calm ? 8'd0 : 8'(pick_gap());
          pending_ops.push_back(r);
        end
        if ($urandom_range(0, 4) == 0) pkt = pkt + $urandom_range(1, 1 << 22);
        else pkt = pkt + $urandom_range(1, 4);
        last_good = evolve_report(last_good, thr, dzv);
        last_good.packet = pkt;
        last_good.gap = calm ? 8'd0 : 8'(pick_gap());
        pending_ops.push_back(last_good);
      end
    end
    last_good = evolve_report(last_good, thr, dzv);
    last_good.packet = 32'hFFFF_FFFF;
    pending_ops.push_back(last_good);
    r = evolve_report(last_good, thr, dzv);
    pending_ops.push_back(r);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || tx_holding || expected_events.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      $display("%0d expected items never arrived", expected_events.size());
      fault_count += expected_events.size();
    end
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
